@@ sv/lbrr_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types.
package lbrr_pkg;

  localparam int REGION_COUNT = 3;
  localparam int RGN_W        = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int OUTER_IDX    = (REGION_COUNT > 2) ? 2 : 0;

  localparam logic [15:0] GAP_BACK  = 16'd16;  // 1 m in Q12.4
  localparam logic [15:0] GAP_FRONT = 16'd32;  // 2 m in Q12.4
  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [15:0] HALF_Q16  = 16'h8000;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMESCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_UP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DOWN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_LIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_LIM = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_LIM  = 3'd7;
  localparam int LIM_REGS = 3;

  localparam logic [31:0] BUDGET_RST    = 32'd2000000;
  localparam logic [31:0] TIMESCALE_RST = 32'd500000000;
  localparam logic [15:0] STEP_RST      = 16'd3277;

  typedef logic [RGN_W-1:0] rgn_t;
  localparam rgn_t LAST_RGN = rgn_t'(REGION_COUNT - 1);

  typedef enum logic [3:0] {
    OP_WDIV, OP_AVG1, OP_AVG2, OP_DSQ, OP_VDD, OP_VAR,
    OP_SQRT, OP_EDIV, OP_EFF, OP_BACK, OP_FRONT
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_WAIT, S_DECIDE, S_CONT_INIT, S_CONT_IN, S_CONT_OUT, S_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic start;
    logic capture;
    logic decide;
    logic cont_init;
    logic cont_in;
    logic cont_out;
    logic load_out;
    op_t  op;
    rgn_t rgn;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic unit_done;
    logic skip;
    logic need_div;
    logic out_free;
  } stat_t;

endpackage

@@ sv/lbrr_mul.sv @@
`timescale 1ns / 1ps
// Shift-add multiplier, one multiplier bit per cycle, stops when the rest is zero.
module lbrr_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [95:0] p
);

  logic        busy_r;
  logic [95:0] acc_r;
  logic [95:0] a_r;
  logic [31:0] b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= (b != 32'd0);
    end else if (busy_r) begin
      busy_r <= (b_r[31:1] != 31'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= {32'd0, a};
      b_r   <= b;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[94:0], 1'b0};
      b_r <= {1'b0, b_r[31:1]};
    end
  end

  assign done = !busy_r;
  assign p    = acc_r;

endmodule

@@ sv/lbrr_div.sv @@
`timescale 1ns / 1ps
// Restoring divider giving a 16-bit quotient; numerator high half must be below the divisor.
module lbrr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [15:0] q
);

  localparam int QW    = 16;
  localparam int CNT_W = $clog2(QW + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      rem_r;
  logic [31:0]      den_r;
  logic [QW-1:0]    sh_r;
  logic [QW-1:0]    q_r;
  logic [32:0]      trial;
  logic             ge;

  assign trial = {rem_r, sh_r[QW-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(QW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[47:16];
      sh_r  <= num[15:0];
      den_r <= den;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      sh_r  <= {sh_r[QW-2:0], 1'b0};
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign done = (cnt_r == '0);
  assign q    = q_r;

endmodule

@@ sv/lbrr_sqrt.sv @@
`timescale 1ns / 1ps
// Bit-pair integer square root of a 64-bit value.
module lbrr_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] v,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] bit_r;
  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (start) begin
      bit_r <= 64'd1 << 62;
    end else if (bit_r != '0) begin
      bit_r <= {2'b00, bit_r[63:2]};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= v;
      res_r <= '0;
    end else if (bit_r != '0) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= {1'b0, res_r[63:1]} + bit_r;
      end else begin
        res_r <= {1'b0, res_r[63:1]};
      end
    end
  end

  assign done = (bit_r == '0);
  assign root = res_r[31:0];

endmodule

@@ sv/lbrr_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer: with regulation enabled, steps each region through the statistics, regulation and nesting passes.
module lbrr_ctrl import lbrr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  rgn_t   rgn_r, rgn_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_WDIV;
      rgn_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      rgn_r   <= rgn_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    rgn_nxt   = rgn_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.enable ? S_START : S_OUT;
          op_nxt    = OP_WDIV;
          rgn_nxt   = '0;
        end
      end
      S_START: state_nxt = S_WAIT;
      S_WAIT: begin
        if (stat.unit_done) begin
          state_nxt = S_START;
          case (op_r)
            OP_WDIV: op_nxt = OP_AVG1;
            OP_AVG1: op_nxt = OP_AVG2;
            OP_AVG2: op_nxt = OP_DSQ;
            OP_DSQ:  op_nxt = OP_VDD;
            OP_VDD:  op_nxt = OP_VAR;
            OP_VAR:  op_nxt = OP_SQRT;
            OP_SQRT: state_nxt = S_DECIDE;
            OP_EDIV: op_nxt = OP_EFF;
            OP_EFF:  op_nxt = OP_BACK;
            OP_BACK: op_nxt = OP_FRONT;
            OP_FRONT: begin
              if (rgn_r == LAST_RGN) begin
                state_nxt = S_CONT_INIT;
                rgn_nxt   = LAST_RGN - 1'b1;
              end else begin
                rgn_nxt = rgn_r + 1'b1;
                op_nxt  = OP_AVG1;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DECIDE: begin
        state_nxt = S_START;
        if (stat.skip) begin
          if (rgn_r == LAST_RGN) begin
            state_nxt = S_CONT_INIT;
            rgn_nxt   = LAST_RGN - 1'b1;
          end else begin
            rgn_nxt = rgn_r + 1'b1;
            op_nxt  = OP_AVG1;
          end
        end else if (stat.need_div) begin
          op_nxt = OP_EDIV;
        end else begin
          op_nxt = OP_EFF;
        end
      end
      S_CONT_INIT: state_nxt = S_CONT_IN;
      S_CONT_IN: begin
        if (rgn_r == '0) begin
          state_nxt = S_CONT_OUT;
          rgn_nxt   = rgn_t'(1);
        end else begin
          rgn_nxt = rgn_r - 1'b1;
        end
      end
      S_CONT_OUT: begin
        if (rgn_r == LAST_RGN) begin
          state_nxt = S_OUT;
        end else begin
          rgn_nxt = rgn_r + 1'b1;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.op   = op_r;
    cmd.rgn  = rgn_r;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_START:     cmd.start     = 1'b1;
      S_WAIT:      cmd.capture   = stat.unit_done;
      S_DECIDE:    cmd.decide    = 1'b1;
      S_CONT_INIT: cmd.cont_init = 1'b1;
      S_CONT_IN:   cmd.cont_in   = 1'b1;
      S_CONT_OUT:  cmd.cont_out  = 1'b1;
      S_OUT:       cmd.load_out  = stat.out_free;
      default: ;
    endcase
  end

endmodule

@@ sv/lbrr_dp.sv @@
`timescale 1ns / 1ps
// Datapath: register file, region statistics and ranges, shared arithmetic units.
module lbrr_dp import lbrr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic [31:0]          in_loop_time_ns,
  input  logic [31:0]          in_physics_time_ns,
  input  logic [31:0]          in_kinematics_time_ns,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_inner_back,
  output logic [15:0]          out_inner_front,
  output logic [15:0]          out_middle_back,
  output logic [15:0]          out_middle_front,
  output logic [15:0]          out_outer_back,
  output logic [15:0]          out_outer_front,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  function automatic logic [15:0] clamp16(input logic [15:0] x, input logic [15:0] lo,
                                          input logic [15:0] hi);
    logic [15:0] y;
    y = (x < lo) ? lo : x;
    return (y > hi) ? hi : y;
  endfunction

  // configuration
  logic        en_r;
  logic [31:0] budget_r, ts_r;
  logic [15:0] up_r, dn_r;
  logic [63:0] lim_r [REGION_COUNT];

  // per-region state
  logic [47:0] avg_r [REGION_COUNT];
  logic [63:0] var_r [REGION_COUNT];
  logic [15:0] rb_r  [REGION_COUNT];
  logic [15:0] rf_r  [REGION_COUNT];

  // working registers
  logic [31:0] loop_r, phys_r, kin_r;
  logic [16:0] w_r, ease_r;
  logic [64:0] t_r;
  logic [63:0] t2_r;
  logic [31:0] noise_r;
  logic [15:0] eff_r;
  logic        below_r;
  logic [15:0] prev_b_r, prev_f_r;
  logic        out_valid_r;
  logic [15:0] o_ib_r, o_if_r, o_mb_r, o_mf_r, o_ob_r, o_of_r;

  logic [47:0] cur_avg;
  logic [63:0] cur_var, cur_lim;
  logic [15:0] cur_rb, cur_rf;
  logic [31:0] meas;
  logic [16:0] w_inv;

  assign cur_avg = avg_r[cmd.rgn];
  assign cur_var = var_r[cmd.rgn];
  assign cur_lim = lim_r[cmd.rgn];
  assign cur_rb  = rb_r[cmd.rgn];
  assign cur_rf  = rf_r[cmd.rgn];
  assign meas    = (cmd.rgn == LAST_RGN) ? kin_r : phys_r;
  assign w_inv   = ONE_Q16 - w_r;

  // rounded absolute deviation in whole ns, capped to 32 bits
  logic [47:0] m16, dq;
  logic [48:0] dr;
  logic [31:0] d;
  assign m16 = {meas, 16'h0};
  assign dq  = (m16 > cur_avg) ? (m16 - cur_avg) : (cur_avg - m16);
  assign dr  = {1'b0, dq} + 49'(HALF_Q16);
  assign d   = dr[48] ? 32'hFFFF_FFFF : dr[47:16];

  // budget offset against noise
  logic [47:0] b16, absoff, noise16, ex;
  logic        below, skip, ease_one;
  assign b16      = {budget_r, 16'h0};
  assign below    = (b16 < cur_avg);
  assign absoff   = below ? (cur_avg - b16) : (b16 - cur_avg);
  assign noise16  = {noise_r, 16'h0};
  assign skip     = (absoff < noise16);
  assign ex       = absoff - noise16;
  assign ease_one = (noise_r == 32'd0) || (ex >= noise16);

  // arithmetic units
  logic        mul_start, div_start, sqrt_start;
  logic        mul_done, div_done, sqrt_done;
  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic [95:0] p;
  logic [47:0] div_num;
  logic [31:0] div_den;
  logic [15:0] div_q;
  logic [31:0] root;
  logic        unit_done;
  logic [15:0] step_sel;

  assign step_sel = below_r ? dn_r : up_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_AVG1:  begin mul_a = {16'd0, cur_avg}; mul_b = {15'd0, w_inv};  end
      OP_AVG2:  begin mul_a = {32'd0, meas};    mul_b = {15'd0, w_r};    end
      OP_DSQ:   begin mul_a = {32'd0, d};       mul_b = d;               end
      OP_VDD:   begin mul_a = t_r[63:0];        mul_b = {15'd0, w_r};    end
      OP_VAR:   begin mul_a = cur_var;          mul_b = {15'd0, w_inv};  end
      OP_EFF:   begin mul_a = {48'd0, step_sel}; mul_b = {15'd0, ease_r}; end
      OP_BACK:  begin mul_a = {48'd0, cur_rb};  mul_b = {16'd0, eff_r};  end
      OP_FRONT: begin mul_a = {48'd0, cur_rf};  mul_b = {16'd0, eff_r};  end
      default: ;
    endcase
  end

  always_comb begin
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    case (cmd.op) inside
      OP_WDIV, OP_EDIV: begin
        div_start = cmd.start;
        unit_done = div_done;
      end
      OP_SQRT: begin
        sqrt_start = cmd.start;
        unit_done  = sqrt_done;
      end
      default: begin
        mul_start = cmd.start;
        unit_done = mul_done;
      end
    endcase
  end

  assign div_num = (cmd.op == OP_WDIV) ? {loop_r, 16'h0} : ex;
  assign div_den = (cmd.op == OP_WDIV) ? ts_r : noise_r;

  lbrr_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(p)
  );

  lbrr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .q(div_q)
  );

  lbrr_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .v(cur_var),
    .done(sqrt_done), .root(root)
  );

  // capture arithmetic
  logic [66:0] avg_sum;
  logic [47:0] avg_new;
  logic [63:0] var_new;
  logic        w_special;
  logic [15:0] rsel, range_new;
  logic [32:0] rnd;
  logic [16:0] delta, grown;

  assign avg_sum   = 67'(t_r) + {p[50:0], 16'h0} + 67'(HALF_Q16);
  assign avg_new   = avg_sum[63:16];
  assign var_new   = p[79:16] + t2_r;
  assign w_special = (ts_r == 32'd0) || (loop_r >= ts_r);
  assign rsel      = (cmd.op == OP_BACK) ? cur_rb : cur_rf;
  assign rnd       = {1'b0, p[31:0]} + 33'(HALF_Q16);
  assign delta     = rnd[32:16];
  assign grown     = {1'b0, rsel} + delta;

  always_comb begin
    if (!below_r) begin
      range_new = grown[16] ? 16'hFFFF : grown[15:0];
    end else begin
      range_new = (delta > {1'b0, rsel}) ? 16'd0 : (rsel - delta[15:0]);
    end
  end

  // nesting against the neighbor region held in prev
  logic [15:0] ob, of_, nb_in, nf_in;
  logic [16:0] ib, if_;
  logic [15:0] ibs, ifs, nb_out, nf_out, cont_b, cont_f;

  assign ob     = (prev_b_r > GAP_BACK)  ? (prev_b_r - GAP_BACK)  : 16'd0;
  assign of_    = (prev_f_r > GAP_FRONT) ? (prev_f_r - GAP_FRONT) : 16'd0;
  assign nb_in  = (cur_rb < ob)  ? cur_rb : ob;
  assign nf_in  = (cur_rf < of_) ? cur_rf : of_;
  assign ib     = {1'b0, prev_b_r} + {1'b0, GAP_BACK};
  assign if_    = {1'b0, prev_f_r} + {1'b0, GAP_FRONT};
  assign ibs    = ib[16]  ? 16'hFFFF : ib[15:0];
  assign ifs    = if_[16] ? 16'hFFFF : if_[15:0];
  assign nb_out = (cur_rb > ibs) ? cur_rb : ibs;
  assign nf_out = (cur_rf > ifs) ? cur_rf : ifs;
  assign cont_b = clamp16(cmd.cont_in ? nb_in : nb_out, cur_lim[15:0], cur_lim[47:32]);
  assign cont_f = clamp16(cmd.cont_in ? nf_in : nf_out, cur_lim[31:16], cur_lim[63:48]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      budget_r    <= BUDGET_RST;
      ts_r        <= TIMESCALE_RST;
      up_r        <= STEP_RST;
      dn_r        <= STEP_RST;
      out_valid_r <= 1'b0;
      for (int k = 0; k < REGION_COUNT; k++) begin
        lim_r[k] <= '0;
        avg_r[k] <= '0;
        var_r[k] <= '0;
        rb_r[k]  <= '0;
        rf_r[k]  <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index) inside
          REG_ENABLE:    en_r     <= cfg_data[0];
          REG_BUDGET:    budget_r <= cfg_data[31:0];
          REG_TIMESCALE: ts_r     <= cfg_data[31:0];
          REG_STEP_UP:   up_r     <= cfg_data[15:0];
          REG_STEP_DOWN: dn_r     <= cfg_data[15:0];
          REG_INNER_LIM, REG_MIDDLE_LIM, REG_OUTER_LIM: begin
            for (int k = 0; k < REGION_COUNT; k++) begin
              if (k < LIM_REGS && 32'(cfg_index) == 32'(REG_INNER_LIM) + 32'(k)) begin
                lim_r[k] <= cfg_data;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd.capture) begin
        case (cmd.op)
          OP_AVG2:  avg_r[cmd.rgn] <= avg_new;
          OP_VAR:   var_r[cmd.rgn] <= var_new;
          OP_BACK:  rb_r[cmd.rgn]  <= range_new;
          OP_FRONT: rf_r[cmd.rgn]  <= range_new;
          default: ;
        endcase
      end
      if (cmd.cont_in || cmd.cont_out) begin
        rb_r[cmd.rgn] <= cont_b;
        rf_r[cmd.rgn] <= cont_f;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      loop_r <= in_loop_time_ns;
      phys_r <= in_physics_time_ns;
      kin_r  <= in_kinematics_time_ns;
    end
    if (cmd.capture) begin
      case (cmd.op)
        OP_WDIV: w_r     <= w_special ? ONE_Q16 : {1'b0, div_q};
        OP_AVG1: t_r     <= p[64:0];
        OP_DSQ:  t_r     <= {1'b0, p[63:0]};
        OP_VDD:  t2_r    <= p[79:16];
        OP_SQRT: noise_r <= root;
        OP_EDIV: ease_r  <= {1'b0, div_q};
        OP_EFF:  eff_r   <= p[31:16];
        default: ;
      endcase
    end
    if (cmd.decide) begin
      below_r <= below;
      if (ease_one) begin
        ease_r <= ONE_Q16;
      end
    end
    if (cmd.cont_init) begin
      prev_b_r <= rb_r[LAST_RGN];
      prev_f_r <= rf_r[LAST_RGN];
    end else if (cmd.cont_in || cmd.cont_out) begin
      prev_b_r <= cont_b;
      prev_f_r <= cont_f;
    end
    if (cmd.load_out) begin
      o_ib_r <= rb_r[0];
      o_if_r <= rf_r[0];
      o_mb_r <= rb_r[1];
      o_mf_r <= rf_r[1];
      o_ob_r <= (REGION_COUNT > 2) ? rb_r[OUTER_IDX] : 16'd0;
      o_of_r <= (REGION_COUNT > 2) ? rf_r[OUTER_IDX] : 16'd0;
    end
  end

  assign stat.enable    = en_r;
  assign stat.unit_done = unit_done;
  assign stat.skip      = skip;
  assign stat.need_div  = !skip && !ease_one;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_inner_back   = o_ib_r;
  assign out_inner_front  = o_if_r;
  assign out_middle_back  = o_mb_r;
  assign out_middle_front = o_mf_r;
  assign out_outer_back   = o_ob_r;
  assign out_outer_front  = o_of_r;

endmodule

@@ sv/load_budget_range_regulator_unit.sv @@
`timescale 1ns / 1ps
// Load budget range regulator: one frame timing sample in, six Q12.4 ranges out.
//
// Input channel (in_valid/in_ready) takes loop, physics and kinematics times.
// Output channel (out_valid/out_ready) returns back/front ranges of the three
// regions, one result per transfer. Config writes (cfg_valid, always ready)
// load register cfg_index with cfg_data; write them only while idle.
// Items are handled one at a time. With regulation on, an item runs the weight
// divide, then per region eight products on the shared shift-add multiplier,
// the square root and, where needed, the ease divide, then the nesting passes;
// a region that holds skips its regulation steps. With regulation off the
// sequencer goes from idle straight to the output state, and out_valid rises
// once the output register is free.
// The result sits in an output register; a stalled receiver only holds the
// block once the next result is done. Synchronous reset clears statistics
// and ranges to zero and loads register defaults.
module load_budget_range_regulator_unit import lbrr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          in_loop_time_ns,
  input  logic [31:0]          in_physics_time_ns,
  input  logic [31:0]          in_kinematics_time_ns,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_inner_back,
  output logic [15:0]          out_inner_front,
  output logic [15:0]          out_middle_back,
  output logic [15:0]          out_middle_front,
  output logic [15:0]          out_outer_back,
  output logic [15:0]          out_outer_front,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  lbrr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  lbrr_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_loop_time_ns(in_loop_time_ns),
    .in_physics_time_ns(in_physics_time_ns),
    .in_kinematics_time_ns(in_kinematics_time_ns),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_inner_back(out_inner_back), .out_inner_front(out_inner_front),
    .out_middle_back(out_middle_back), .out_middle_front(out_middle_front),
    .out_outer_back(out_outer_back), .out_outer_front(out_outer_front),
    .cfg_valid(cfg_valid & cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

endmodule

@@ sv/lbrr_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the regulator, bound to the top level.
module lbrr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_inner_back,
  input logic [15:0] out_outer_front
);

  // leaving reset: no stale result, ready for a sample
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // one sample at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a new result only appears from the busy phase
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a sample in work");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inner_back)
      && $stable(out_outer_front))
    else $error("stalled result changed");

endmodule

bind load_budget_range_regulator_unit lbrr_checker u_lbrr_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_inner_back(out_inner_back), .out_outer_front(out_outer_front)
);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the load budget range regulator.
module tb;
  import lbrr_pkg::*;

  typedef struct packed {
    logic [15:0] inner_back;
    logic [15:0] inner_front;
    logic [15:0] middle_back;
    logic [15:0] middle_front;
    logic [15:0] outer_back;
    logic [15:0] outer_front;
  } ranges_t;

  // directed row: phase, known-result flag, inputs, typed ranges
  typedef struct packed {
    logic [3:0]  phase;
    logic        known;
    logic [31:0] loop_t;
    logic [31:0] phys_t;
    logic [31:0] kin_t;
    ranges_t     ranges;
  } frame_row_t;

  localparam int DIR_ROWS = 20;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_FRAMES = 150;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [31:0] in_loop_time_ns, in_physics_time_ns, in_kinematics_time_ns;
  logic out_valid, out_ready;
  logic [15:0] out_inner_back, out_inner_front, out_middle_back, out_middle_front;
  logic [15:0] out_outer_back, out_outer_front;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  load_budget_range_regulator_unit dut (.*);

  // predictor state
  bit          reg_enable;
  bit [31:0]   reg_budget, reg_timescale;
  bit [15:0]   reg_step_up, reg_step_down;
  bit [63:0]   reg_limits[3];
  bit [47:0]   avg_q16[3];
  bit [63:0]   var_ns2[3];
  bit [15:0]   back_rng[3], front_rng[3];

  ranges_t     ranges_due[$];
  int          fail_count;
  bit          no_idle;
  frame_row_t  dir_rows[DIR_ROWS];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic bit [63:0] frac_mul(bit [63:0] x, bit [63:0] w);
    return (x >> 16) * w + (((x & 64'hFFFF) * w) >> 16);
  endfunction

  function automatic bit [63:0] root64(bit [63:0] v);
    bit [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic bit [15:0] scale_rng(bit [15:0] r, bit [31:0] eff, bit grow);
    bit [63:0] delta;
    bit [63:0] s;
    delta = (64'(r) * eff + 64'd32768) >> 16;
    if (grow) begin
      s = 64'(r) + delta;
      return (s > 64'd65535) ? 16'hFFFF : s[15:0];
    end
    return (delta > 64'(r)) ? 16'd0 : 16'(64'(r) - delta);
  endfunction

  function automatic bit [15:0] clamp_rng(bit [16:0] x, bit [15:0] lo, bit [15:0] hi);
    if (x < 17'(lo)) x = 17'(lo);
    if (x > 17'(hi)) x = 17'(hi);
    return x[15:0];
  endfunction

  function automatic void track_region(int r, bit [63:0] w, bit [31:0] meas);
    bit [63:0] m16, avg, dq, d, vr, noise16, b16, absoff, ease, ex;
    bit [31:0] eff, step;
    bit below;
    m16 = 64'(meas) << 16;
    avg = 64'(avg_q16[r]);
    avg = (avg * (64'd65536 - w) + m16 * w + 64'd32768) >> 16;
    avg_q16[r] = avg[47:0];
    avg = 64'(avg_q16[r]);
    dq = (m16 > avg) ? m16 - avg : avg - m16;
    d = (dq + 64'd32768) >> 16;
    if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
    vr = frac_mul(var_ns2[r], 64'd65536 - w) + frac_mul(d * d, w);
    var_ns2[r] = vr;
    noise16 = root64(vr) << 16;
    b16 = 64'(reg_budget) << 16;
    below = b16 < avg;
    absoff = below ? avg - b16 : b16 - avg;
    if (absoff < noise16) return;
    if (noise16 == 0) begin
      ease = 64'd65536;
    end else begin
      ex = absoff - noise16;
      ease = (ex >= noise16) ? 64'd65536 : (ex << 16) / noise16;
    end
    step = below ? 32'(reg_step_down) : 32'(reg_step_up);
    eff = 32'((64'(step) * ease) >> 16);
    back_rng[r] = scale_rng(back_rng[r], eff, !below);
    front_rng[r] = scale_rng(front_rng[r], eff, !below);
  endfunction

  function automatic void nest_regions();
    bit [16:0] ob, ofr, b, f;
    for (int i = 1; i >= 0; i--) begin
      ob = (back_rng[i+1] > GAP_BACK) ? 17'(back_rng[i+1] - GAP_BACK) : 17'd0;
      ofr = (front_rng[i+1] > GAP_FRONT) ? 17'(front_rng[i+1] - GAP_FRONT) : 17'd0;
      b = (17'(back_rng[i]) < ob) ? 17'(back_rng[i]) : ob;
      f = (17'(front_rng[i]) < ofr) ? 17'(front_rng[i]) : ofr;
      back_rng[i] = clamp_rng(b, reg_limits[i][15:0], reg_limits[i][47:32]);
      front_rng[i] = clamp_rng(f, reg_limits[i][31:16], reg_limits[i][63:48]);
    end
    for (int i = 1; i < 3; i++) begin
      ob = 17'(back_rng[i-1]) + 17'(GAP_BACK);
      ofr = 17'(front_rng[i-1]) + 17'(GAP_FRONT);
      if (ob > 17'd65535) ob = 17'd65535;
      if (ofr > 17'd65535) ofr = 17'd65535;
      b = (17'(back_rng[i]) > ob) ? 17'(back_rng[i]) : ob;
      f = (17'(front_rng[i]) > ofr) ? 17'(front_rng[i]) : ofr;
      back_rng[i] = clamp_rng(b, reg_limits[i][15:0], reg_limits[i][47:32]);
      front_rng[i] = clamp_rng(f, reg_limits[i][31:16], reg_limits[i][63:48]);
    end
  endfunction

  function automatic ranges_t regulate_frame(bit [31:0] lt, bit [31:0] pt, bit [31:0] kt);
    bit [63:0] w;
    ranges_t o;
    if (reg_enable) begin
      if (reg_timescale == 0 || lt >= reg_timescale) w = 64'd65536;
      else w = (64'(lt) << 16) / 64'(reg_timescale);
      track_region(0, w, pt);
      track_region(1, w, pt);
      track_region(2, w, kt);
      nest_regions();
    end
    o = '{back_rng[0], front_rng[0], back_rng[1], front_rng[1], back_rng[2], front_rng[2]};
    return o;
  endfunction

  // called at a negedge; returns at a negedge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLE:    reg_enable = val[0];
      REG_BUDGET:    reg_budget = val[31:0];
      REG_TIMESCALE: reg_timescale = val[31:0];
      REG_STEP_UP:   reg_step_up = val[15:0];
      REG_STEP_DOWN: reg_step_down = val[15:0];
      REG_INNER_LIM: reg_limits[0] = val;
      REG_MIDDLE_LIM: reg_limits[1] = val;
      REG_OUTER_LIM: reg_limits[2] = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_frame(logic [31:0] lt, logic [31:0] pt, logic [31:0] kt,
                            bit known, ranges_t typed);
    ranges_t pred;
    if (!no_idle && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(13, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_loop_time_ns <= lt;
    in_physics_time_ns <= pt;
    in_kinematics_time_ns <= kt;
    do @(posedge clk); while (!in_ready);
    pred = regulate_frame(lt, pt, kt);
    ranges_due.insert(ranges_due.size(), known ? typed : pred);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (ranges_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_limits();
    logic [15:0] lo_b, lo_f, hi_b, hi_f;
    logic [63:0] v;
    if ($urandom_range(7) == 0) begin
      v = {$urandom, $urandom};
      return v;
    end
    lo_b = 16'($urandom_range(800));
    lo_f = 16'($urandom_range(1600));
    hi_b = lo_b + 16'($urandom_range(30000));
    hi_f = lo_f + 16'($urandom_range(60000 - 1600));
    return {hi_f, hi_b, lo_f, lo_b};
  endfunction

  task automatic set_phase(int ph);
    case (ph)
      1: begin
        write_reg(REG_ENABLE, 64'd1);
        write_reg(REG_INNER_LIM, {16'h0800, 16'h0400, 16'h0020, 16'h0010});
        write_reg(REG_MIDDLE_LIM, {16'h2000, 16'h1000, 16'h0100, 16'h0080});
        write_reg(REG_OUTER_LIM, {16'hFFFF, 16'hFFFF, 16'h0200, 16'h0100});
      end
      2: begin
        write_reg(REG_BUDGET, 64'd0);
        write_reg(REG_TIMESCALE, 64'd0);
        write_reg(REG_STEP_UP, 64'hFFFF);
        write_reg(REG_STEP_DOWN, 64'hFFFF);
        // min above max on the inner region
        write_reg(REG_INNER_LIM, {16'h0010, 16'h0010, 16'hFFFF, 16'hFFFF});
      end
      3: begin
        write_reg(REG_BUDGET, 64'hFFFF_FFFF);
        write_reg(REG_TIMESCALE, 64'd1);
        write_reg(REG_STEP_UP, 64'd0);
        write_reg(REG_STEP_DOWN, 64'd0);
        write_reg(REG_OUTER_LIM, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      end
      4: begin
        write_reg(REG_TIMESCALE, 64'hFFFF_FFFF);
        write_reg(REG_STEP_UP, 64'hFFFF);
        write_reg(REG_BUDGET, 64'd2000000);
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] near_time(logic [31:0] centre, int spread);
    longint v;
    v = longint'(centre) + longint'($urandom_range(2 * spread)) - longint'(spread);
    if (v < 0) v = 0;
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    return v[31:0];
  endfunction

  initial begin
    in_valid = 1'b0;
    in_loop_time_ns = '0;
    in_physics_time_ns = '0;
    in_kinematics_time_ns = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    fail_count = 0;
    no_idle = 1'b0;
    reg_enable = 1'b0;
    reg_budget = BUDGET_RST;
    reg_timescale = TIMESCALE_RST;
    reg_step_up = STEP_RST;
    reg_step_down = STEP_RST;
    for (int r = 0; r < 3; r++) begin
      reg_limits[r] = '0;
      avg_q16[r] = '0;
      var_ns2[r] = '0;
      back_rng[r] = '0;
      front_rng[r] = '0;
    end

    // phase 0 rows: regulation off after reset, so all ranges read zero
    dir_rows = '{
      '{4'd0, 1'b1, 32'd0, 32'd0, 32'd0, '0},
      '{4'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0},
      '{4'd0, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, '0},
      '{4'd0, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, '0},
      '{4'd1, 1'b0, 32'd16000000, 32'd1000000, 32'd500000, '0},
      '{4'd1, 1'b0, 32'd16000000, 32'd3000000, 32'd4000000, '0},
      '{4'd1, 1'b0, 32'd0, 32'd2000000, 32'd2000000, '0},
      '{4'd1, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0, '0},
      '{4'd1, 1'b0, 32'd1000000, 32'd100, 32'd5000000, '0},
      '{4'd2, 1'b0, 32'd5, 32'd0, 32'd0, '0},
      '{4'd2, 1'b0, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0},
      '{4'd2, 1'b0, 32'd5, 32'd0, 32'hFFFF_FFFF, '0},
      '{4'd2, 1'b0, 32'd5, 32'hFFFF_FFFF, 32'd0, '0},
      '{4'd3, 1'b0, 32'd0, 32'd0, 32'd0, '0},
      '{4'd3, 1'b0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF, '0},
      '{4'd3, 1'b0, 32'd7, 32'd0, 32'd1, '0},
      '{4'd4, 1'b0, 32'd16000000, 32'd1000, 32'd1000, '0},
      '{4'd4, 1'b0, 32'hFFFF_FFFF, 32'd1000, 32'd1000, '0},
      '{4'd4, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0},
      '{4'd4, 1'b0, 32'd0, 32'd2000000, 32'd0, '0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == 0 || dir_rows[i].phase != dir_rows[i-1].phase) begin
        drain_results();
        set_phase(int'(dir_rows[i].phase));
      end
      send_frame(dir_rows[i].loop_t, dir_rows[i].phys_t, dir_rows[i].kin_t,
                 dir_rows[i].known, dir_rows[i].ranges);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      logic [31:0] centre;
      int spread, pick;
      drain_results();
      write_reg(REG_ENABLE, ($urandom_range(5) == 0) ? 64'd0 : 64'd1);
      pick = $urandom_range(3);
      centre = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF
             : 32'($urandom_range(20000000, 500000));
      write_reg(REG_BUDGET, 64'(centre));
      pick = $urandom_range(4);
      write_reg(REG_TIMESCALE, (pick == 0) ? 64'd0 : (pick == 1) ? 64'd1
                : (pick == 2) ? 64'hFFFF_FFFF : 64'($urandom_range(200000000, 1000000)));
      write_reg(REG_STEP_UP, ($urandom_range(4) == 0) ? 64'hFFFF : 64'($urandom_range(65535)));
      write_reg(REG_STEP_DOWN, ($urandom_range(4) == 0) ? 64'd0 : 64'($urandom_range(65535)));
      write_reg(REG_INNER_LIM, rand_limits());
      write_reg(REG_MIDDLE_LIM, rand_limits());
      write_reg(REG_OUTER_LIM, rand_limits());
      cfg_valid <= 1'b0;
      @(negedge clk);
      if (centre == 0 || centre == 32'hFFFF_FFFF) centre = 32'($urandom_range(20000000, 500000));
      spread = int'(centre / 2);
      no_idle = (ph == RAND_PHASES - 1);
      for (int k = 0; k < PHASE_FRAMES; k++) begin
        // in the third random phase the sender holds off midway until the block is empty
        if (ph == 2 && k == PHASE_FRAMES / 2) begin
          in_valid <= 1'b0;
          while (ranges_due.size() != 0) @(negedge clk);
        end
        if ($urandom_range(9) == 0)
          send_frame($urandom, $urandom, $urandom, 1'b0, '0);
        else
          send_frame(32'($urandom_range(33000000, 100000)), near_time(centre, spread),
                     near_time(centre, spread), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (ranges_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && ranges_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver with bursts of stall
  initial begin : rx_stall
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(4) == 0) begin
        hold = $urandom_range(13, 1) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    ranges_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_inner_back, out_inner_front, out_middle_back, out_middle_front,
              out_outer_back, out_outer_front};
      if (ranges_due.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual %h", $time, got);
        fail_count++;
      end else begin
        want = ranges_due.pop_front();
        if (got.inner_back !== want.inner_back)
          $display("%0t: inner_back expected %h actual %h", $time, want.inner_back,
                   got.inner_back);
        if (got.inner_front !== want.inner_front)
          $display("%0t: inner_front expected %h actual %h", $time, want.inner_front,
                   got.inner_front);
        if (got.middle_back !== want.middle_back)
          $display("%0t: middle_back expected %h actual %h", $time, want.middle_back,
                   got.middle_back);
        if (got.middle_front !== want.middle_front)
          $display("%0t: middle_front expected %h actual %h", $time, want.middle_front,
                   got.middle_front);
        if (got.outer_back !== want.outer_back)
          $display("%0t: outer_back expected %h actual %h", $time, want.outer_back,
                   got.outer_back);
        if (got.outer_front !== want.outer_front)
          $display("%0t: outer_front expected %h actual %h", $time, want.outer_front,
                   got.outer_front);
        if (got !== want) fail_count++;
      end
    end
  end

endmodule
